### hw/rtl/mieu_pkg.sv
package mieu_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned IDX_W  = 5;
   localparam int unsigned OP_W   = 5;
   localparam int unsigned IMM_W  = 16;

   localparam logic [OP_W-1:0] OP_ADD   = 5'd0;
   localparam logic [OP_W-1:0] OP_ADDU  = 5'd1;
   localparam logic [OP_W-1:0] OP_SUB   = 5'd2;
   localparam logic [OP_W-1:0] OP_SUBU  = 5'd3;
   localparam logic [OP_W-1:0] OP_AND   = 5'd4;
   localparam logic [OP_W-1:0] OP_OR    = 5'd5;
   localparam logic [OP_W-1:0] OP_XOR   = 5'd6;
   localparam logic [OP_W-1:0] OP_NOR   = 5'd7;
   localparam logic [OP_W-1:0] OP_SLT   = 5'd8;
   localparam logic [OP_W-1:0] OP_SLTU  = 5'd9;
   localparam logic [OP_W-1:0] OP_ADDI  = 5'd10;
   localparam logic [OP_W-1:0] OP_ADDIU = 5'd11;
   localparam logic [OP_W-1:0] OP_ANDI  = 5'd12;
   localparam logic [OP_W-1:0] OP_ORI   = 5'd13;
   localparam logic [OP_W-1:0] OP_XORI  = 5'd14;
   localparam logic [OP_W-1:0] OP_LUI   = 5'd15;
   localparam logic [OP_W-1:0] OP_SLTI  = 5'd16;
   localparam logic [OP_W-1:0] OP_SLTIU = 5'd17;
   localparam logic [OP_W-1:0] OP_SLL   = 5'd18;
   localparam logic [OP_W-1:0] OP_SRL   = 5'd19;
   localparam logic [OP_W-1:0] OP_SRA   = 5'd20;
   localparam logic [OP_W-1:0] OP_SLLV  = 5'd21;
   localparam logic [OP_W-1:0] OP_SRLV  = 5'd22;
   localparam logic [OP_W-1:0] OP_SRAV  = 5'd23;
   localparam logic [OP_W-1:0] OP_MULT  = 5'd24;
   localparam logic [OP_W-1:0] OP_MULTU = 5'd25;
   localparam logic [OP_W-1:0] OP_DIV   = 5'd26;
   localparam logic [OP_W-1:0] OP_DIVU  = 5'd27;
   localparam logic [OP_W-1:0] OP_MFHI  = 5'd28;
   localparam logic [OP_W-1:0] OP_MFLO  = 5'd29;
   localparam logic [OP_W-1:0] OP_MTHI  = 5'd30;
   localparam logic [OP_W-1:0] OP_MTLO  = 5'd31;

   localparam int unsigned LUI_SHIFT = 16;

   typedef struct packed {
      logic [OP_W-1:0]  opcode;
      logic [IDX_W-1:0] dest_reg;
      logic [IDX_W-1:0] src_reg;
      logic [IDX_W-1:0] target_reg;
      logic [IDX_W-1:0] shift_amount;
      logic [IMM_W-1:0] immediate;
   } req_type;

   typedef struct packed {
      logic              reg_written;
      logic [IDX_W-1:0]  written_index;
      logic [DATA_W-1:0] written_value;
      logic              overflow_trap;
      logic [DATA_W-1:0] hi_value;
      logic [DATA_W-1:0] lo_value;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic is_div;
      logic is_signed;
   } md_ctl_type;

endpackage

### hw/rtl/mieu_ram.sv
module mieu_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### hw/rtl/mieu_muldiv.sv
module mieu_muldiv (
   input  logic                       clock,
   input  logic                       reset,
   input  mieu_pkg::md_ctl_type       ctl,
   input  logic [mieu_pkg::DATA_W-1:0] op_a,
   input  logic [mieu_pkg::DATA_W-1:0] op_b,
   output logic                       done,
   output logic [mieu_pkg::DATA_W-1:0] hi_out,
   output logic [mieu_pkg::DATA_W-1:0] lo_out
);

   localparam logic [2:0] M_IDLE = 3'd0;
   localparam logic [2:0] M_MUL1 = 3'd1;
   localparam logic [2:0] M_MUL2 = 3'd2;
   localparam logic [2:0] M_DIV  = 3'd3;
   localparam logic [2:0] M_FIN  = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [31:0] a_ff, a_in, b_ff, b_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        sgn_ff, sgn_in, neg_q_ff, neg_q_in, neg_r_ff, neg_r_in;
   logic        done_ff, done_in;
   logic [31:0] hi_ff, hi_in, lo_ff, lo_in;
   logic [32:0] shifted;
   logic [33:0] diff;
   logic        na, nb;

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      prod_in  = prod_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      sgn_in   = sgn_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      done_in  = done_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      na       = ctl.is_signed & op_a[31];
      nb       = ctl.is_signed & op_b[31];
      shifted  = {rem_ff[31:0], quo_ff[31]};
      diff     = {1'b0, shifted} - {2'b00, b_ff};
      case (state_ff)
         M_IDLE: begin
            if (ctl.start) begin
               done_in = 1'b0;
               sgn_in  = ctl.is_signed;
               if (ctl.is_div) begin
                  quo_in   = na ? (32'd0 - op_a) : op_a;
                  b_in     = nb ? (32'd0 - op_b) : op_b;
                  rem_in   = '0;
                  cnt_in   = '0;
                  neg_q_in = na ^ nb;
                  neg_r_in = na;
                  state_in = M_DIV;
               end else begin
                  a_in     = op_a;
                  b_in     = op_b;
                  state_in = M_MUL1;
               end
            end
         end
         M_MUL1: begin
            prod_in  = 64'(a_ff) * 64'(b_ff);
            state_in = M_MUL2;
         end
         M_MUL2: begin
            // fold the unsigned product into a signed one
            hi_in = prod_ff[63:32] - ((sgn_ff & a_ff[31]) ? b_ff : 32'd0)
                    - ((sgn_ff & b_ff[31]) ? a_ff : 32'd0);
            lo_in    = prod_ff[31:0];
            done_in  = 1'b1;
            state_in = M_IDLE;
         end
         M_DIV: begin
            if (diff[33]) begin
               rem_in = shifted;
               quo_in = {quo_ff[30:0], 1'b0};
            end else begin
               rem_in = diff[32:0];
               quo_in = {quo_ff[30:0], 1'b1};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = M_FIN;
            end
         end
         M_FIN: begin
            lo_in    = neg_q_ff ? (32'd0 - quo_ff) : quo_ff;
            hi_in    = neg_r_ff ? (32'd0 - rem_ff[31:0]) : rem_ff[31:0];
            done_in  = 1'b1;
            state_in = M_IDLE;
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      a_ff     <= a_in;
      b_ff     <= b_in;
      prod_ff  <= prod_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      sgn_ff   <= sgn_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
   end

   assign done   = done_ff;
   assign hi_out = hi_ff;
   assign lo_out = lo_ff;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> state_ff == M_IDLE)
      else $error("muldiv done while busy");
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      (ctl.start && state_ff == M_IDLE) |=> !done_ff)
      else $error("done not cleared on start");
   a_mul_seq: assert property (@(posedge clock) disable iff (reset)
      state_ff == M_MUL1 |=> state_ff == M_MUL2)
      else $error("multiply sequence broken");

endmodule

### hw/rtl/mips_integer_execute_unit.sv
// channel | ports                                | payload
// input   | req_valid, req_stall, req_item       | mieu_pkg::req_type
// result  | rsp_valid, rsp_stall, rsp_item       | mieu_pkg::rsp_type
// ALU, shift and HI/LO move items: from accept, the operands are read and forwarded,
//    then executed; the next item is accepted on the edge that registers the result.
// mult/multu and div/divu run in mieu_muldiv, div/divu on the one-bit-per-cycle divider;
//    input stalls until the result is registered, so no new item is accepted meanwhile.
// Reset clears HI, LO and the valid bits of the register file; no clearing pass.
// A stalled result is held in the output register; execute waits only if it is still full.
module mips_integer_execute_unit #(
   parameter int unsigned REG_COUNT = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mieu_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mieu_pkg::rsp_type rsp_item
);

   localparam int unsigned AW = $clog2(REG_COUNT);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RD   = 2'd1;
   localparam logic [1:0] S_EX   = 2'd2;
   localparam logic [1:0] S_MD   = 2'd3;

   logic [1:0]           state_ff, state_in;
   mieu_pkg::req_type    item_ff, item_in;
   logic [31:0]          a_ff, a_in, b_ff, b_in;
   logic [31:0]          hi_ff, hi_in, lo_ff, lo_in;
   logic [REG_COUNT-1:0] valid_ff, valid_in;
   logic                 fwd_en_ff;
   logic [AW-1:0]        fwd_idx_ff;
   logic [31:0]          fwd_val_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   mieu_pkg::rsp_type    rsp_ff, rsp_in;
   logic [31:0]          rd_a, rd_b;
   logic                 accept, slot_free, ex_done;
   logic                 wr_want, wr_en, trap, is_md;
   logic [AW-1:0]        wr_idx;
   logic [31:0]          r, sx, zx, sum, dif, sumi;
   mieu_pkg::md_ctl_type md_ctl;
   logic                 md_done;
   logic [31:0]          md_hi, md_lo;

   mieu_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_ram_rs (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_idx), .wr_data(r),
      .rd_addr(req_item.src_reg[AW-1:0]), .rd_data(rd_a));

   mieu_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_ram_rt (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_idx), .wr_data(r),
      .rd_addr(req_item.target_reg[AW-1:0]), .rd_data(rd_b));

   mieu_muldiv u_muldiv (
      .clock(clock), .reset(reset), .ctl(md_ctl), .op_a(a_ff), .op_b(b_ff),
      .done(md_done), .hi_out(md_hi), .lo_out(md_lo));

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign is_md     = item_ff.opcode inside {mieu_pkg::OP_MULT, mieu_pkg::OP_MULTU,
                                             mieu_pkg::OP_DIV, mieu_pkg::OP_DIVU};
   assign ex_done   = state_ff == S_EX && !is_md && slot_free;
   assign req_stall = !(state_ff == S_IDLE || ex_done);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      sx   = {{16{item_ff.immediate[15]}}, item_ff.immediate};
      zx   = {16'd0, item_ff.immediate};
      sum  = a_ff + b_ff;
      dif  = a_ff - b_ff;
      sumi = a_ff + sx;
      r       = '0;
      wr_want = 1'b1;
      trap    = 1'b0;
      wr_idx  = item_ff.dest_reg[AW-1:0];
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      case (item_ff.opcode)
         mieu_pkg::OP_ADD: begin
            r    = sum;
            trap = ((a_ff ^ sum) & (b_ff ^ sum)) >> 31 != 32'd0;
         end
         mieu_pkg::OP_ADDU: r = sum;
         mieu_pkg::OP_SUB: begin
            r    = dif;
            trap = ((a_ff ^ b_ff) & (a_ff ^ dif)) >> 31 != 32'd0;
         end
         mieu_pkg::OP_SUBU: r = dif;
         mieu_pkg::OP_AND:  r = a_ff & b_ff;
         mieu_pkg::OP_OR:   r = a_ff | b_ff;
         mieu_pkg::OP_XOR:  r = a_ff ^ b_ff;
         mieu_pkg::OP_NOR:  r = ~(a_ff | b_ff);
         mieu_pkg::OP_SLT:  r = {31'd0, $signed(a_ff) < $signed(b_ff)};
         mieu_pkg::OP_SLTU: r = {31'd0, a_ff < b_ff};
         mieu_pkg::OP_SLL:  r = b_ff << item_ff.shift_amount;
         mieu_pkg::OP_SRL:  r = b_ff >> item_ff.shift_amount;
         mieu_pkg::OP_SRA:  r = 32'($signed(b_ff) >>> item_ff.shift_amount);
         mieu_pkg::OP_SLLV: r = b_ff << a_ff[4:0];
         mieu_pkg::OP_SRLV: r = b_ff >> a_ff[4:0];
         mieu_pkg::OP_SRAV: r = 32'($signed(b_ff) >>> a_ff[4:0]);
         mieu_pkg::OP_MFHI: r = hi_ff;
         mieu_pkg::OP_MFLO: r = lo_ff;
         mieu_pkg::OP_MULT, mieu_pkg::OP_MULTU, mieu_pkg::OP_DIV, mieu_pkg::OP_DIVU: begin
            wr_want = 1'b0;
            hi_in   = md_hi;
            lo_in   = md_lo;
         end
         mieu_pkg::OP_MTHI: begin
            wr_want = 1'b0;
            hi_in   = a_ff;
         end
         mieu_pkg::OP_MTLO: begin
            wr_want = 1'b0;
            lo_in   = a_ff;
         end
         default: begin
            // immediate formats write rt
            wr_idx = item_ff.target_reg[AW-1:0];
            case (item_ff.opcode)
               mieu_pkg::OP_ADDI: begin
                  r    = sumi;
                  trap = ((a_ff ^ sumi) & (sx ^ sumi)) >> 31 != 32'd0;
               end
               mieu_pkg::OP_ADDIU: r = sumi;
               mieu_pkg::OP_ANDI:  r = a_ff & zx;
               mieu_pkg::OP_ORI:   r = a_ff | zx;
               mieu_pkg::OP_XORI:  r = a_ff ^ zx;
               mieu_pkg::OP_LUI:   r = zx << mieu_pkg::LUI_SHIFT;
               mieu_pkg::OP_SLTI:  r = {31'd0, $signed(a_ff) < $signed(sx)};
               mieu_pkg::OP_SLTIU: r = {31'd0, a_ff < sx};
               default:            r = '0;
            endcase
         end
      endcase
   end

   assign wr_en = ex_done && wr_want && !trap && wr_idx != '0;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      md_ctl       = '{start: 1'b0, is_div: item_ff.opcode[1],
                       is_signed: !item_ff.opcode[0]};
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            // entry 0 and never-written entries read zero; forward the last write
            if (item_ff.src_reg == '0) begin
               a_in = '0;
            end else if (fwd_en_ff && fwd_idx_ff == item_ff.src_reg[AW-1:0]) begin
               a_in = fwd_val_ff;
            end else begin
               a_in = valid_ff[item_ff.src_reg[AW-1:0]] ? rd_a : '0;
            end
            if (item_ff.target_reg == '0) begin
               b_in = '0;
            end else if (fwd_en_ff && fwd_idx_ff == item_ff.target_reg[AW-1:0]) begin
               b_in = fwd_val_ff;
            end else begin
               b_in = valid_ff[item_ff.target_reg[AW-1:0]] ? rd_b : '0;
            end
            state_in = S_EX;
         end
         S_EX: begin
            if (is_md) begin
               md_ctl.start = 1'b1;
               state_in     = S_MD;
            end else if (ex_done) begin
               state_in = accept ? S_RD : S_IDLE;
            end
         end
         S_MD: begin
            if (md_done && slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (accept) begin
         item_in = req_item;
      end
      if (wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
      if (ex_done || (state_ff == S_MD && md_done && slot_free)) begin
         rsp_valid_in         = 1'b1;
         rsp_in.reg_written   = wr_en;
         rsp_in.written_index = wr_en ? wr_idx : '0;
         rsp_in.written_value = wr_en ? r : '0;
         rsp_in.overflow_trap = trap;
         rsp_in.hi_value      = hi_in;
         rsp_in.lo_value      = lo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         hi_ff        <= '0;
         lo_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         fwd_en_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         fwd_en_ff    <= wr_en;
         if (ex_done || (state_ff == S_MD && md_done && slot_free)) begin
            hi_ff <= hi_in;
            lo_ff <= lo_in;
         end
      end
      item_ff    <= item_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      rsp_ff     <= rsp_in;
      fwd_idx_ff <= wr_idx;
      fwd_val_ff <= r;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_trap_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.overflow_trap |-> !rsp_ff.reg_written)
      else $error("trapped item wrote a register");
   a_no_zero_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> wr_idx != '0)
      else $error("write to register zero");
   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_RD)
      else $error("accepted item not read");
   a_held_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("stalled result lost");

endmodule
